### rtl/bs_pkg.sv
// shared types and constants for the bitonic sorter unit
`default_nettype none

package bs_pkg;

    // element width and default block length
    localparam int VALUE_W       = 32;
    localparam int SORT_SIZE_DEF = 16;

    typedef logic signed [VALUE_W-1:0] t_value;

    // operation that the controller applies to every cell in a cycle
    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_INSERT,
        CELL_SHIFT_DN,
        CELL_SHIFT_UP
    } t_cell_op;

    // control word broadcast along the cell row
    typedef struct packed {
        t_cell_op op;
        t_value   value;
    } t_cell_ctrl;

endpackage

`default_nettype wire

### rtl/bs_if.sv
// word channels of the sorter: input values and sorted output values
`default_nettype none

interface bs_in_if;
    logic            valid;
    logic            ready;
    bs_pkg::t_value  value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

interface bs_out_if;
    logic            valid;
    logic            ready;
    bs_pkg::t_value  sorted_value;
    logic            last;

    modport source (output valid, output sorted_value, output last, input ready);
    modport sink   (input valid, input sorted_value, input last, output ready);
endinterface

`default_nettype wire

### rtl/bitonic_sorter_unit.sv
// top level of the block sorter: cell row plus load and emit control
//
// Usage: a block of SORT_SIZE signed 32-bit words enters on i_in, one word
// per accepted handshake. Each word is inserted into a row of cells that
// keeps the loaded words in ascending order, so the block is sorted when its
// last word arrives. The block then leaves on o_out, smallest first when
// sort_ascending was 1 at the final load and largest first otherwise; last
// marks the final word. The row shifts one place per delivered word.
// Latency: the first sorted word is valid the cycle after the final load.
// Throughput: one word per cycle in, then one per cycle out while the
// receiver is ready; the single row of cells serves one block at a time,
// so i_in.ready is low while a block drains. A stalled receiver holds the
// row and the current word.
// Reset (i_rst_n, synchronous) empties the row and sets sort_ascending to 1.
// i_cfg_we/i_cfg_wdata write sort_ascending; the write takes effect for the
// block whose final word is loaded after it.
`default_nettype none

module bitonic_sorter_unit #(
    parameter int SORT_SIZE = bs_pkg::SORT_SIZE_DEF
) (
    input  wire               i_clk,
    input  wire               i_rst_n,
    bs_in_if.sink             i_in,
    bs_out_if.source          o_out,
    input  wire               i_cfg_we,
    input  wire               i_cfg_wdata
);

    localparam int CW = $clog2(SORT_SIZE + 1);
    localparam logic [CW-1:0] LAST_IDX = CW'(SORT_SIZE - 1);

    typedef enum logic {
        ST_LOAD,
        ST_EMIT
    } t_state;

    t_state            r_state;
    logic [CW-1:0]     r_count;
    logic              r_asc;
    logic              r_dir;

    bs_pkg::t_cell_ctrl w_ctrl;
    logic               w_gt   [SORT_SIZE];
    bs_pkg::t_value     w_data [SORT_SIZE];

    logic w_in_acc;
    logic w_out_acc;

    assign w_in_acc  = i_in.valid && i_in.ready;
    assign w_out_acc = o_out.valid && o_out.ready;

    // channel outputs
    assign i_in.ready         = (r_state == ST_LOAD);
    assign o_out.valid        = (r_state == ST_EMIT);
    assign o_out.sorted_value = r_dir ? w_data[0] : w_data[SORT_SIZE-1];
    assign o_out.last         = (r_count == LAST_IDX);

    // operation broadcast to the row
    always_comb begin
        w_ctrl.value = i_in.value;
        w_ctrl.op    = bs_pkg::CELL_HOLD;
        if (w_in_acc) begin
            w_ctrl.op = bs_pkg::CELL_INSERT;
        end else if (w_out_acc) begin
            w_ctrl.op = r_dir ? bs_pkg::CELL_SHIFT_DN : bs_pkg::CELL_SHIFT_UP;
        end
    end

    // row of cells
    genvar gi;
    generate
        for (gi = 0; gi < SORT_SIZE; gi++) begin : g_cell
            logic           w_occ;
            logic           w_prev_gt;
            bs_pkg::t_value w_prev_data;
            bs_pkg::t_value w_next_data;

            assign w_occ = (CW'(gi) < r_count) && (r_state == ST_LOAD);

            if (gi == 0) begin : g_first
                assign w_prev_gt   = 1'b0;
                assign w_prev_data = '0;
            end else begin : g_mid
                assign w_prev_gt   = w_gt[gi-1];
                assign w_prev_data = w_data[gi-1];
            end

            if (gi == SORT_SIZE - 1) begin : g_last
                assign w_next_data = '0;
            end else begin : g_inner
                assign w_next_data = w_data[gi+1];
            end

            bs_cell u_cell (
                .i_clk       (i_clk),
                .i_ctrl      (w_ctrl),
                .i_occ       (w_occ),
                .i_prev_gt   (w_prev_gt),
                .i_prev_data (w_prev_data),
                .i_next_data (w_next_data),
                .o_gt        (w_gt[gi]),
                .o_data      (w_data[gi])
            );
        end
    endgenerate

    // load/emit sequencer, word count and direction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_LOAD;
            r_count <= '0;
            r_asc   <= 1'b1;
            r_dir   <= 1'b1;
        end else begin
            if (i_cfg_we) begin
                r_asc <= i_cfg_wdata;
            end
            unique case (r_state)
                ST_LOAD: begin
                    if (w_in_acc) begin
                        if (r_count == LAST_IDX) begin
                            r_state <= ST_EMIT;
                            r_count <= '0;
                            r_dir   <= r_asc;
                        end else begin
                            r_count <= r_count + CW'(1);
                        end
                    end
                end
                ST_EMIT: begin
                    if (w_out_acc) begin
                        if (r_count == LAST_IDX) begin
                            r_state <= ST_LOAD;
                            r_count <= '0;
                        end else begin
                            r_count <= r_count + CW'(1);
                        end
                    end
                end
                default: begin
                    r_state <= ST_LOAD;
                    r_count <= '0;
                end
            endcase
        end
    end

    // loading and draining never overlap
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_in.ready && o_out.valid))
        else $error("load and emit active together");

    // final load starts the drain at the first word
    a_load_to_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && r_count == LAST_IDX) |=> (o_out.valid && r_count == '0))
        else $error("drain did not start after final load");

    // last word delivered returns the row to loading
    a_emit_to_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_out_acc && o_out.last) |=> (i_in.ready && r_count == '0))
        else $error("row not reopened after final word");

    // direction is fixed for the whole drain
    a_dir_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && $past(o_out.valid)) |-> $stable(r_dir))
        else $error("sort direction changed during drain");

endmodule

`default_nettype wire

### rtl/bs_cell.sv
// one cell of the sorting row: holds one element, inserts or shifts with its neighbors
`default_nettype none

module bs_cell (
    input  wire                  i_clk,
    input  bs_pkg::t_cell_ctrl   i_ctrl,
    input  wire                  i_occ,
    input  wire                  i_prev_gt,
    input  bs_pkg::t_value       i_prev_data,
    input  bs_pkg::t_value       i_next_data,
    output logic                 o_gt,
    output bs_pkg::t_value       o_data
);

    bs_pkg::t_value r_data;
    bs_pkg::t_value n_data;

    // new word belongs before this cell's element (an empty cell always yields)
    assign o_gt   = !i_occ || (r_data > i_ctrl.value);
    assign o_data = r_data;

    // next element: insert opens a gap by taking the lower neighbor's element
    always_comb begin
        n_data = r_data;
        case (i_ctrl.op)
            bs_pkg::CELL_INSERT: begin
                if (o_gt) begin
                    n_data = i_prev_gt ? i_prev_data : i_ctrl.value;
                end
            end
            bs_pkg::CELL_SHIFT_DN: n_data = i_next_data;
            bs_pkg::CELL_SHIFT_UP: n_data = i_prev_data;
            default:               n_data = r_data;
        endcase
    end

    // element register
    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

endmodule

`default_nettype wire

### sim/bs_sort_checker.sv
// word monitor, block sort predictor and result comparator for the sorter unit
`default_nettype none

module bs_sort_checker #(
    parameter int BLOCK_LEN = bs_pkg::SORT_SIZE_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    bs_in_if     i_in,
    bs_out_if    o_out,
    input  logic i_cfg_we,
    input  logic i_cfg_wdata,
    output int   o_fail_count,
    output int   o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        bs_pkg::t_value value;
        logic           last;
    } t_sorted_word;

    // words of the block being loaded, and the sorted words still owed
    bs_pkg::t_value load_buf [BLOCK_LEN];
    int             load_fill;
    logic           sort_up;
    t_sorted_word   sorted_due_q [$];
    int             fails;

    // sort the loaded block in the selected direction and queue its words
    function automatic void queue_sorted_block(input logic up);
        bs_pkg::t_value ordered [BLOCK_LEN];
        bs_pkg::t_value key;
        int             j;
        t_sorted_word   w;
        for (int i = 0; i < BLOCK_LEN; i++) ordered[i] = load_buf[i];
        for (int i = 1; i < BLOCK_LEN; i++) begin
            key = ordered[i];
            j = i - 1;
            while (j >= 0 && (up ? (ordered[j] > key) : (ordered[j] < key))) begin
                ordered[j + 1] = ordered[j];
                j--;
            end
            ordered[j + 1] = key;
        end
        for (int i = 0; i < BLOCK_LEN; i++) begin
            w.value = ordered[i];
            w.last  = (i == BLOCK_LEN - 1);
            sorted_due_q.push_back(w);
        end
    endfunction

    initial begin
        fails     = 0;
        load_fill = 0;
        sort_up   = 1'b1;
    end

    always @(posedge i_clk) begin : watch
        t_sorted_word head;
        if (!i_rst_n) begin
            load_fill = 0;
            sort_up   = 1'b1;
            sorted_due_q.delete();
        end else begin
            // compare each delivered word with the oldest one owed
            if (o_out.valid && o_out.ready) begin
                if (sorted_due_q.size() == 0) begin
                    $display("%0t: unexpected word: expected none, got %0d last %0b",
                             $time, o_out.sorted_value, o_out.last);
                    fails++;
                end else begin
                    head = sorted_due_q.pop_front();
                    if (head.value !== o_out.sorted_value || head.last !== o_out.last) begin
                        $display("%0t: word mismatch: expected %0d last %0b, got %0d last %0b",
                                 $time, head.value, head.last, o_out.sorted_value,
                                 o_out.last);
                        fails++;
                    end
                end
            end
            // collect accepted words; a full block is sorted at its final load
            if (i_in.valid && i_in.ready) begin
                load_buf[load_fill] = i_in.value;
                load_fill++;
                if (load_fill == BLOCK_LEN) begin
                    queue_sorted_block(sort_up);
                    load_fill = 0;
                end
            end
            // direction register
            if (i_cfg_we) sort_up = i_cfg_wdata;
        end
        o_fail_count <= fails;
        o_pending    <= sorted_due_q.size();
    end

endmodule

`default_nettype wire

### sim/tb_bitonic_sorter_unit.sv
// testbench top for the sorter unit: clock, reset, word stimulus and verdict
`default_nettype none

module tb_bitonic_sorter_unit;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int             BLOCK_LEN      = bs_pkg::SORT_SIZE_DEF;
    localparam int             RESET_CYCLES   = 11;
    localparam int             STALL_LIMIT    = 3000;
    localparam int             HOLD_CYCLES    = 300;
    localparam int             DRAIN_CYCLES   = 20;
    localparam int             BLOCKS_PER_RUN = 9;
    localparam bs_pkg::t_value VALUE_MAX      = 32'sh7FFF_FFFF;
    localparam bs_pkg::t_value VALUE_MIN      = 32'sh8000_0000;

    typedef enum int {
        FILL_RANDOM,
        FILL_NARROW,
        FILL_EXTREME,
        FILL_RAMP_DOWN
    } t_fill_kind;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic cfg_wdata;
    int   fail_count;
    int   pending;
    int   rx_idle_pct;
    int   tx_idle_pct;
    logic hold_toggle;
    logic hold_seen;
    int   hold_left;
    int   stall_cycles;

    bs_in_if  in_ch ();
    bs_out_if out_ch ();

    bitonic_sorter_unit #(
        .SORT_SIZE (BLOCK_LEN)
    ) uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in        (in_ch),
        .o_out       (out_ch),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata)
    );

    bs_sort_checker #(
        .BLOCK_LEN (BLOCK_LEN)
    ) u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in         (in_ch),
        .o_out        (out_ch),
        .i_cfg_we     (cfg_we),
        .i_cfg_wdata  (cfg_wdata),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // clock
    initial begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // receiver: random back-pressure, or a long hold when one is requested
    initial hold_seen = 1'b0;
    always @(posedge clk) begin
        if (hold_toggle != hold_seen) begin
            hold_seen    <= hold_toggle;
            hold_left    <= HOLD_CYCLES;
            out_ch.ready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left    <= hold_left - 1;
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= ($urandom_range(0, 99) >= rx_idle_pct);
        end
    end

    // watchdog on cycles where no word moves on either side
    always @(posedge clk) begin
        if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("Some tests failed");
                $finish;
            end
        end
    end

    // offer one word, with random gaps, until it is taken
    task automatic send_word(input bs_pkg::t_value v);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.value <= v;
        @(posedge clk);
        while (!in_ch.ready) @(posedge clk);
    endtask

    // stop offering and let every owed word come out
    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_direction(input logic up);
        cfg_we    <= 1'b1;
        cfg_wdata <= up;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    function automatic bs_pkg::t_value pick_word(input t_fill_kind kind);
        bs_pkg::t_value v;
        case (kind)
            FILL_NARROW: v = $signed($urandom_range(0, 8)) - 4;
            FILL_EXTREME: begin
                case ($urandom_range(0, 5))
                    0:       v = VALUE_MAX;
                    1:       v = VALUE_MIN;
                    2:       v = 0;
                    3:       v = -1;
                    4:       v = 1;
                    default: v = $urandom;
                endcase
            end
            default: v = $urandom;
        endcase
        return v;
    endfunction

    task automatic send_block(input t_fill_kind kind);
        bs_pkg::t_value base;
        int             step;
        base = $urandom;
        step = $urandom_range(1, 1000);
        for (int i = 0; i < BLOCK_LEN; i++) begin
            if (kind == FILL_RAMP_DOWN) send_word(base - i * step);
            else                        send_word(pick_word(kind));
        end
    endtask

    // stimulus and verdict
    initial begin
        bs_pkg::t_value extreme_words [BLOCK_LEN];
        extreme_words = '{VALUE_MAX, VALUE_MIN, 0, -1, 1, VALUE_MAX - 1, VALUE_MIN + 1,
                          5, 5, 5, -5, 32'sh4000_0000, 32'shC000_0000,
                          32'sh5555_5555, 32'shAAAA_AAAA, 0};
        rst_n        <= 1'b0;
        in_ch.valid  <= 1'b0;
        in_ch.value  <= '0;
        cfg_we       <= 1'b0;
        cfg_wdata    <= 1'b0;
        rx_idle_pct  <= 0;
        hold_toggle  <= 1'b0;
        hold_left    <= 0;
        tx_idle_pct  = 0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // extremes and duplicates with the direction left at its reset value
        for (int i = 0; i < BLOCK_LEN; i++) send_word(extreme_words[i]);
        wait_drained();

        // direction flipped halfway through a block; second half all equal
        for (int i = 0; i < BLOCK_LEN / 2; i++) send_word(i * 3 - 20);
        wait_drained();
        write_direction(1'b0);
        for (int i = 0; i < BLOCK_LEN / 2; i++) send_word(42);
        wait_drained();

        // random blocks: slow receiver, then slow sender, then full rate
        for (int run = 0; run < 3; run++) begin
            case (run)
                0: begin tx_idle_pct = 10; rx_idle_pct <= 65; end
                1: begin tx_idle_pct = 65; rx_idle_pct <= 10; end
                default: begin tx_idle_pct = 0; rx_idle_pct <= 0; end
            endcase
            wait_drained();
            write_direction(run != 1);
            for (int b = 0; b < BLOCKS_PER_RUN; b++) begin
                if (run == 2 && b == 3) begin
                    // hold the receiver off while two blocks are offered
                    hold_toggle <= ~hold_toggle;
                end else if ($urandom_range(0, 2) == 0) begin
                    wait_drained();
                    write_direction(1'($urandom_range(0, 1)));
                end
                send_block(t_fill_kind'($urandom_range(0, 3)));
            end
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0 && pending == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

`default_nettype wire

### files.f
rtl/bs_pkg.sv
rtl/bs_if.sv
rtl/bs_cell.sv
rtl/bitonic_sorter_unit.sv
sim/bs_sort_checker.sv
sim/tb_bitonic_sorter_unit.sv
